// ===== sv/spq_pkg.sv =====
// Shared types and constants for the stable priority queue.
package spq_pkg;

    // Default number of queue slots
    localparam int CAPACITY_DEF = 16;

    // Fixed field widths
    localparam int VAL_W       = 32;
    localparam int CNT_OUT_W   = 5;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // One command transfer
    typedef struct packed {
        logic                    cmd;
        logic signed [VAL_W-1:0] item_value;
        logic signed [VAL_W-1:0] item_priority;
    } t_in_item;

    // One result transfer
    typedef struct packed {
        logic                    ok;
        logic signed [VAL_W-1:0] head_value;
        logic [CNT_OUT_W-1:0]    entry_count;
        logic                    is_empty;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the accepted command
        logic exec;   // apply it to the slots and register the result
    } t_ctrl_cmd;

endpackage

// ===== sv/stable_priority_queue_top.sv =====
// Top level of the stable priority queue: controller plus slot datapath.
//
// Usage:
//   Command channel (i_in_valid / o_in_ready / i_in_data): cmd = insert
//   places item_value after every stored entry of greater or equal
//   priority, so equal priorities leave in arrival order; cmd = remove
//   drops the head entry. An insert into a full queue or a remove from an
//   empty queue fails with ok = 0 and leaves the queue unchanged.
//   Result channel (o_out_valid / i_out_ready / o_out_data): exactly one
//   result per command: ok, head value after the operation (0 when empty),
//   entry count and empty flag.
//   A result is valid at the end of the execute cycle that follows its
//   command transfer.
//   A new command is taken only after the capture and the single execute
//   step of the last one, in which all slots compare and shift in
//   parallel.
//   The result register holds while the receiver stalls; the next command
//   is taken once the pending result transfers (in the same cycle).
//   Reset (synchronous, active low) empties the queue; slot contents are
//   not cleared and are never read before being written.
module stable_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  spq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output spq_pkg::t_out_item o_out_data
);
    import spq_pkg::*;

    t_ctrl_cmd ctrl_cmd;

    // Handshake sequencing
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (ctrl_cmd)
    );

    // Slot chain and result
    spq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (ctrl_cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

// ===== sv/spq_ctrl.sv =====
// Handshake controller for the stable priority queue.
module spq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output spq_pkg::t_ctrl_cmd o_cmd
);
    import spq_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic in_xfer;

    // Accept only when idle and the result register is free or draining
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (r_out_valid && i_out_ready) begin
                    n_out_valid = 1'b0;
                end
                if (in_xfer) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec  = 1'b1;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // An execute step always leads to a pending result
    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_out_valid && r_state == S_IDLE))
        else $error("execute step did not raise the result");

    // A result is never overwritten while waiting
    a_no_exec_over_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !r_out_valid)
        else $error("execute step while a result is pending");

endmodule

// ===== sv/spq_datapath.sv =====
// Slot chain, occupancy count and result register of the stable priority queue.
module spq_datapath #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spq_pkg::t_ctrl_cmd i_cmd,
    input  spq_pkg::t_in_item  i_in_data,
    output spq_pkg::t_out_item o_out_data
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Captured command
    t_in_item r_in;

    // Slot chain, head in slot 0
    logic signed [VAL_W-1:0] r_val [CAPACITY];
    logic signed [VAL_W-1:0] r_pri [CAPACITY];
    logic signed [VAL_W-1:0] n_val [CAPACITY];
    logic signed [VAL_W-1:0] n_pri [CAPACITY];

    logic [CNT_W-1:0] r_count, n_count;
    t_out_item        r_res;

    logic [CAPACITY-1:0] ge;      // occupied slot that stays ahead of the new entry
    logic                is_full;
    logic                is_remove;
    logic                op_ok;
    logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

    assign is_full   = (r_count == CNT_W'(CAPACITY));
    assign is_remove = (r_in.cmd == CMD_REMOVE);
    assign op_ok     = is_remove ? (r_count != '0) : !is_full;

    // Per-slot compare and shift select
    for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
        logic signed [VAL_W-1:0] ins_val, ins_pri, rem_val, rem_pri;

        assign ge[g] = (CNT_W'(g) < r_count) && (r_pri[g] >= r_in.item_priority);

        if (g == 0) begin : g_head
            assign ins_val = ge[g] ? r_val[g] : r_in.item_value;
            assign ins_pri = ge[g] ? r_pri[g] : r_in.item_priority;
        end else begin : g_body
            assign ins_val = ge[g]   ? r_val[g] :
                             ge[g-1] ? r_in.item_value : r_val[g-1];
            assign ins_pri = ge[g]   ? r_pri[g] :
                             ge[g-1] ? r_in.item_priority : r_pri[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign rem_val = r_val[g];
            assign rem_pri = r_pri[g];
        end else begin : g_mid
            assign rem_val = r_val[g+1];
            assign rem_pri = r_pri[g+1];
        end

        assign n_val[g] = is_remove ? rem_val : ins_val;
        assign n_pri[g] = is_remove ? rem_pri : ins_pri;
    end

    // Occupancy after the operation
    always_comb begin
        n_count = r_count;
        if (op_ok) begin
            n_count = is_remove ? r_count - 1'b1 : r_count + 1'b1;
        end
    end

    assign cnt_ext = {{CNT_OUT_W{1'b0}}, n_count};

    // Command capture, slot update and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
        if (i_cmd.exec) begin
            if (op_ok) begin
                for (int k = 0; k < CAPACITY; k++) begin
                    r_val[k] <= n_val[k];
                    r_pri[k] <= n_pri[k];
                end
            end
            r_res.ok          <= op_ok;
            // a failed command leaves the head where it was
            r_res.head_value  <= (n_count == '0) ? '0 : (op_ok ? n_val[0] : r_val[0]);
            r_res.entry_count <= cnt_ext[CNT_OUT_W-1:0];
            r_res.is_empty    <= (n_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    assign o_out_data = r_res;

    // Occupancy stays within the slot count
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("occupancy beyond capacity");

    // A successful insert grows the queue by one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && !is_remove && !is_full) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the queue");

    // A remove on an empty queue fails and leaves it empty
    a_empty_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && is_remove && r_count == '0) |=> (r_count == '0 && !r_res.ok))
        else $error("remove on empty queue misbehaved");

    // Result empty flag agrees with the stored occupancy
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> (r_res.is_empty == (r_count == '0)))
        else $error("empty flag disagrees with occupancy");

endmodule

// ===== tb/tb_stable_priority_queue_top.sv =====
// Testbench for the stable priority queue: sorted-list prediction and result checking.
`timescale 1ns / 100ps

module tb_stable_priority_queue_top;

    import spq_pkg::*;

    // Number of random commands after the directed part
    localparam int RANDOM_CMDS = 1800;

    // Sorted-list mirror of the queue plus the results it still expects
    class sorted_queue_checker;
        logic signed [VAL_W-1:0] slot_val[$];
        logic signed [VAL_W-1:0] slot_pri[$];
        t_out_item               pending_results[$];
        int                      mismatch_count;
        int                      result_index;

        function new();
            mismatch_count = 0;
            result_index   = 0;
        endfunction

        // Apply one accepted command and queue the result it must give
        function void apply_command(t_in_item c);
            t_out_item r;
            int        pos;
            r.ok = 1'b0;
            if (c.cmd == CMD_INSERT) begin
                if (slot_pri.size() < CAPACITY_DEF) begin
                    // stable: skip every entry of greater or equal priority
                    pos = 0;
                    while (pos < slot_pri.size() && slot_pri[pos] >= c.item_priority)
                        pos++;
                    slot_pri.insert(pos, c.item_priority);
                    slot_val.insert(pos, c.item_value);
                    r.ok = 1'b1;
                end
            end else if (slot_pri.size() > 0) begin
                slot_pri.delete(0);
                slot_val.delete(0);
                r.ok = 1'b1;
            end
            r.head_value  = (slot_val.size() > 0) ? slot_val[0] : '0;
            r.entry_count = CNT_OUT_W'(slot_val.size());
            r.is_empty    = (slot_val.size() == 0);
            pending_results.push_back(r);
        endfunction

        task report_mismatch(input string what);
            $display("ERROR: result %0d at %0t: %s", result_index, $realtime, what);
            mismatch_count++;
        endtask

        // Compare one result transfer against the oldest expectation
        task check_result(input t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result ok=%b head=%h cnt=%0d empty=%b",
                                          got.ok, got.head_value, got.entry_count,
                                          got.is_empty));
            end else begin
                want = pending_results.pop_front();
                if (got.ok !== want.ok)
                    report_mismatch($sformatf("ok %b, want %b", got.ok, want.ok));
                if (got.head_value !== want.head_value)
                    report_mismatch($sformatf("head_value %h, want %h",
                                              got.head_value, want.head_value));
                if (got.entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count %0d, want %0d",
                                              got.entry_count, want.entry_count));
                if (got.is_empty !== want.is_empty)
                    report_mismatch($sformatf("is_empty %b, want %b",
                                              got.is_empty, want.is_empty));
            end
            result_index++;
        endtask
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    sorted_queue_checker queue_checker;
    bit                  allow_idle;

    stable_priority_queue_top #(
        .CAPACITY (CAPACITY_DEF)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_in_item make_cmd(logic c, logic [VAL_W-1:0] v, logic [VAL_W-1:0] p);
        t_in_item r;
        r.cmd           = c;
        r.item_value    = v;
        r.item_priority = p;
        return r;
    endfunction

    // Offer one command, idling at random first, and note it on transfer
    task automatic send_command(input t_in_item c);
        bit done;
        done = 1'b0;
        while (!done) begin
            @(negedge i_clk);
            if (allow_idle && $urandom_range(99) < 20) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_in_data  <= c;
                do @(posedge i_clk); while (!o_in_ready);
                queue_checker.apply_command(c);
                done = 1'b1;
            end
        end
    endtask

    // Receiver: random stalls on the result channel
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= (allow_idle && $urandom_range(99) < 20) ? 1'b0 : 1'b1;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            queue_checker.check_result(o_out_data);
    end

    // Stimulus
    initial begin
        t_in_item directed[$];
        t_in_item c;
        bit       fill_bias;
        int       n;

        queue_checker = new();
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        allow_idle = 1'b1;
        fill_bias  = 1'b1;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Remove from an empty queue fails
        directed.push_back(make_cmd(CMD_REMOVE, 32'h0, 32'h0));
        // Priority extremes, signed ordering and ties filling all 16 slots
        directed.push_back(make_cmd(CMD_INSERT, 32'h7fff_ffff, 32'h8000_0000));
        directed.push_back(make_cmd(CMD_INSERT, 32'h8000_0000, 32'h7fff_ffff));
        directed.push_back(make_cmd(CMD_INSERT, 32'h1, 32'h0));
        directed.push_back(make_cmd(CMD_INSERT, 32'h2, 32'h0));
        directed.push_back(make_cmd(CMD_INSERT, 32'h3, 32'h0));
        directed.push_back(make_cmd(CMD_INSERT, 32'h4, 32'hffff_ffff));
        directed.push_back(make_cmd(CMD_INSERT, 32'h5, 32'h1));
        directed.push_back(make_cmd(CMD_INSERT, 32'h6, 32'h7fff_ffff));
        directed.push_back(make_cmd(CMD_INSERT, 32'h7, 32'h8000_0000));
        directed.push_back(make_cmd(CMD_INSERT, 32'h8, 32'd100));
        directed.push_back(make_cmd(CMD_INSERT, 32'h9, -32'sd100));
        directed.push_back(make_cmd(CMD_INSERT, 32'ha, 32'h0));
        directed.push_back(make_cmd(CMD_INSERT, 32'hb, 32'h4000_0000));
        directed.push_back(make_cmd(CMD_INSERT, 32'hc, 32'hc000_0000));
        directed.push_back(make_cmd(CMD_INSERT, 32'hd, 32'h1));
        directed.push_back(make_cmd(CMD_INSERT, 32'he, 32'hffff_ffff));
        // Insert into a full queue fails
        directed.push_back(make_cmd(CMD_INSERT, 32'hf, 32'h0));
        // Drain part of it; removes carry junk in the ignored fields
        repeat (6)
            directed.push_back(make_cmd(CMD_REMOVE, 32'hffff_ffff, 32'hffff_ffff));

        foreach (directed[k])
            send_command(directed[k]);

        // Random bursts that lean towards filling or draining, with many ties
        for (n = 0; n < RANDOM_CMDS; n++) begin
            if (n % 20 == 0)
                fill_bias = $urandom_range(1);
            allow_idle = !(n >= 700 && n < 1000);
            c.cmd        = (($urandom_range(99) < 70) == fill_bias) ? CMD_INSERT : CMD_REMOVE;
            c.item_value = $urandom();
            case ($urandom_range(3))
                0, 1:    c.item_priority = VAL_W'(int'($urandom_range(6)) - 3);
                2:       c.item_priority = $urandom();
                default: begin
                    case ($urandom_range(3))
                        0:       c.item_priority = 32'h8000_0000;
                        1:       c.item_priority = 32'h7fff_ffff;
                        2:       c.item_priority = '0;
                        default: c.item_priority = '1;
                    endcase
                end
            endcase
            send_command(c);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Drain outstanding results, then keep watching for stray ones
        while (queue_checker.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (queue_checker.mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
